[src/sfr_pkg.sv]
`default_nettype none
package sfr_pkg;

   // datagram geometry
   localparam int MAX_DATAGRAM_BYTES = 32;
   localparam int FRAME_LEN          = 21;
   localparam int CRC_SPAN           = 19;
   localparam int PAYLOAD_LEN        = 16;
   localparam int POS_W              = $clog2(MAX_DATAGRAM_BYTES + 1);
   localparam int PAYLOAD_IDX_W      = $clog2(PAYLOAD_LEN);

   // checksum and keystream constants
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [31:0] SEED_FALLBACK = 32'hA5A5A5A5;

   // register defaults
   localparam logic [7:0]  NETWORK_ID_RESET = 8'hA1;
   localparam logic [31:0] KEY_WORD_RESET   = 32'h496F5432;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // register indexes
   typedef enum logic [0:0] {
      CSR_NETWORK_ID = 1'b0,
      CSR_KEY_WORD   = 1'b1
   } csr_index_type;

   // result codes
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_LEN = 2'd1,
      STATUS_BAD_CRC = 2'd2,
      STATUS_REPLAY  = 2'd3
   } status_type;

   // role of a byte inside the datagram
   typedef enum logic [2:0] {
      CLS_HEAD,
      CLS_NONCE_LO,
      CLS_NONCE_HI,
      CLS_PAYLOAD,
      CLS_TRAIL_LO,
      CLS_TRAIL_HI,
      CLS_IGNORE
   } byte_class_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [7:0]        sensor_id;
      logic signed [31:0] temperature;
      logic [15:0]       humidity;
      logic [31:0]       pressure;
      logic [31:0]       light;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  network_id;
      logic [31:0] key_word;
   } cfg_type;

   // classified byte passed from front to back
   typedef struct packed {
      logic [7:0]               rx_byte;
      logic                     frame_end;
      byte_class_type           cls;
      logic [PAYLOAD_IDX_W-1:0] pay_idx;
      logic                     len_ok;
   } item_type;

   // queue handshake seen by the back
   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   // one byte of crc-16/modbus, reflected
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // xorshift32 with shifts 13, 17, 5
   function automatic logic [31:0] xorshift32(input logic [31:0] s);
      logic [31:0] x;
      x = s;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return x;
   endfunction

endpackage
`default_nettype wire

[src/sfr_front.sv]
`default_nettype none
module sfr_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire sfr_pkg::req_type req_data,
   output logic                  req_ready,
   input  wire logic             q_full,
   output logic                  q_push,
   output sfr_pkg::item_type     q_item
);
   import sfr_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept;

   // classify the byte by its position
   always_comb begin
      q_item.rx_byte   = req_data.rx_byte;
      q_item.frame_end = req_data.frame_end;
      q_item.pay_idx   = PAYLOAD_IDX_W'(pos_ff - POS_W'(3));
      q_item.len_ok    = (pos_ff == POS_W'(FRAME_LEN - 1));
      if (pos_ff == POS_W'(0)) begin
         q_item.cls = CLS_HEAD;
      end else if (pos_ff == POS_W'(1)) begin
         q_item.cls = CLS_NONCE_LO;
      end else if (pos_ff == POS_W'(2)) begin
         q_item.cls = CLS_NONCE_HI;
      end else if (pos_ff < POS_W'(CRC_SPAN)) begin
         q_item.cls = CLS_PAYLOAD;
      end else if (pos_ff == POS_W'(CRC_SPAN)) begin
         q_item.cls = CLS_TRAIL_LO;
      end else if (pos_ff == POS_W'(CRC_SPAN + 1)) begin
         q_item.cls = CLS_TRAIL_HI;
      end else begin
         q_item.cls = CLS_IGNORE;
      end
   end

   // saturating byte position, cleared after the last byte
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (req_data.frame_end) begin
            pos_in = '0;
         end else if (pos_ff < POS_W'(MAX_DATAGRAM_BYTES)) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule
`default_nettype wire

[src/sfr_queue.sv]
`default_nettype none
module sfr_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire sfr_pkg::item_type       push_item,
   input  wire logic                    pop,
   output sfr_pkg::item_type            pop_item,
   output sfr_pkg::queue_status_type    status
);
   import sfr_pkg::*;

   item_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_item     = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

[src/sfr_back.sv]
`default_nettype none
module sfr_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire sfr_pkg::cfg_type         cfg,
   input  wire sfr_pkg::queue_status_type q_status,
   input  wire sfr_pkg::item_type        q_item,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output sfr_pkg::rsp_type              rsp_data
);
   import sfr_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic [31:0] prng_ff, prng_in;
   logic [15:0] nonce_ff, nonce_in;
   logic        header_ok_ff, header_ok_in;
   logic [15:0] trailer_ff, trailer_in;
   logic [15:0] last_nonce_ff, last_nonce_in;
   logic        first_frame_ff, first_frame_in;
   logic [7:0]  payload_ff [PAYLOAD_LEN];
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        can_load;
   logic        finish;
   logic        pay_write;
   logic [7:0]  pay_byte;
   logic [31:0] seed;
   logic [31:0] prng_step;
   status_type  status;

   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign q_pop     = q_status.valid && (!q_item.frame_end || can_load);
   assign finish    = q_pop && q_item.frame_end;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign seed      = cfg.key_word ^ {q_item.rx_byte, nonce_ff[7:0],
                                      q_item.rx_byte, nonce_ff[7:0]};
   assign prng_step = xorshift32(prng_ff);
   assign pay_byte  = q_item.rx_byte ^ prng_step[7:0];
   assign pay_write = q_pop && (q_item.cls == CLS_PAYLOAD);

   // per-byte frame state update
   always_comb begin
      crc_in       = crc_ff;
      prng_in      = prng_ff;
      nonce_in     = nonce_ff;
      header_ok_in = header_ok_ff;
      trailer_in   = trailer_ff;
      case (q_item.cls)
         CLS_HEAD: begin
            crc_in       = crc_byte(crc_ff, q_item.rx_byte);
            header_ok_in = (q_item.rx_byte == cfg.network_id);
         end
         CLS_NONCE_LO: begin
            crc_in   = crc_byte(crc_ff, q_item.rx_byte);
            nonce_in = {nonce_ff[15:8], q_item.rx_byte};
         end
         CLS_NONCE_HI: begin
            crc_in   = crc_byte(crc_ff, q_item.rx_byte);
            nonce_in = {q_item.rx_byte, nonce_ff[7:0]};
            prng_in  = (seed != '0) ? seed : SEED_FALLBACK;
         end
         CLS_PAYLOAD: begin
            crc_in  = crc_byte(crc_ff, q_item.rx_byte);
            prng_in = prng_step;
         end
         CLS_TRAIL_LO: begin
            trailer_in = {trailer_ff[15:8], q_item.rx_byte};
         end
         CLS_TRAIL_HI: begin
            trailer_in = {q_item.rx_byte, trailer_ff[7:0]};
         end
         default: begin
         end
      endcase
   end

   // frame verdict, checked in order length/id, crc, replay
   always_comb begin
      if (!q_item.len_ok || !header_ok_in) begin
         status = STATUS_BAD_LEN;
      end else if (crc_in != trailer_in) begin
         status = STATUS_BAD_CRC;
      end else if (!first_frame_ff && (nonce_in == last_nonce_ff)) begin
         status = STATUS_REPLAY;
      end else begin
         status = STATUS_OK;
      end
   end

   // output register and replay history
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      last_nonce_in  = last_nonce_ff;
      first_frame_in = first_frame_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in.status = status;
         if (status == STATUS_OK) begin
            last_nonce_in          = nonce_in;
            first_frame_in         = 1'b0;
            rsp_data_in.sensor_id  = payload_ff[0];
            rsp_data_in.temperature = {payload_ff[4], payload_ff[3],
                                       payload_ff[2], payload_ff[1]};
            rsp_data_in.humidity   = {payload_ff[6], payload_ff[5]};
            rsp_data_in.pressure   = {payload_ff[10], payload_ff[9],
                                      payload_ff[8], payload_ff[7]};
            rsp_data_in.light      = {payload_ff[14], payload_ff[13],
                                      payload_ff[12], payload_ff[11]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff         <= CRC_INIT;
         prng_ff        <= '0;
         nonce_ff       <= '0;
         header_ok_ff   <= 1'b0;
         trailer_ff     <= '0;
         last_nonce_ff  <= '0;
         first_frame_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         last_nonce_ff  <= last_nonce_in;
         first_frame_ff <= first_frame_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (finish) begin
            crc_ff       <= CRC_INIT;
            prng_ff      <= '0;
            nonce_ff     <= '0;
            header_ok_ff <= 1'b0;
            trailer_ff   <= '0;
         end else if (q_pop) begin
            crc_ff       <= crc_in;
            prng_ff      <= prng_in;
            nonce_ff     <= nonce_in;
            header_ok_ff <= header_ok_in;
            trailer_ff   <= trailer_in;
         end
      end
   end

   // result payload holds without reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // decrypted payload store
   always_ff @(posedge clock) begin
      if (pay_write) begin
         payload_ff[q_item.pay_idx] <= pay_byte;
      end
   end

endmodule
`default_nettype wire

[src/secure_frame_receiver_unit.sv]
// secure frame receiver: one datagram byte per beat, verdict on the last byte
// throughput: one byte per cycle while the queue is not full; one result per datagram
// result path: the last byte is written into the queue; once the output register can
// load, the queue entry is checked and its verdict lands in the output register
// reset clears byte position, queue, frame state, replay history and
// registers to defaults; the decrypted payload store is not reset
`default_nettype none
module secure_frame_receiver_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire sfr_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output sfr_pkg::rsp_type       rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [0:0]        csr_index,
   input  wire logic [31:0]       csr_data
);
   import sfr_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             q_push;
   logic             q_pop;
   item_type         push_item;
   item_type         pop_item;
   queue_status_type q_status;

   assign csr_ready = 1'b1;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_NETWORK_ID: cfg_in.network_id = csr_data[7:0];
            CSR_KEY_WORD:   cfg_in.key_word   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.network_id <= NETWORK_ID_RESET;
         cfg_ff.key_word   <= KEY_WORD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // byte classification
   sfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .q_full    (q_status.full),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   // decoupling queue
   sfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   // check, decrypt and report
   sfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .q_item    (pop_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[sim/secure_frame_receiver_unit_test.sv]
`timescale 1ns / 1ps

module secure_frame_receiver_unit_test;
   import sfr_pkg::*;

   // byte positions inside a datagram
   localparam int POS_HEAD     = 0;
   localparam int POS_NONCE_LO = 1;
   localparam int POS_NONCE_HI = 2;
   localparam int POS_PAYLOAD  = 3;
   localparam int POS_TRAIL_LO = CRC_SPAN;
   localparam int POS_TRAIL_HI = CRC_SPAN + 1;

   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_BYTES  = 25;
   localparam int PHASE_COUNT  = 8;

   typedef enum int {
      FLOW_FREE,
      FLOW_SEND_GAPS,
      FLOW_RECV_STALLS,
      FLOW_BOTH
   } flow_type;

   // plaintext pattern of a built frame
   typedef enum int {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_ONES,
      FILL_SIGN
   } fill_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [0:0]    csr_index = '0;
   logic [31:0]   csr_data = '0;

   // stimulus side
   req_type       pending_bytes[$];
   flow_type      flow = FLOW_FREE;
   int            bytes_queued = 0;
   logic [7:0]    cfg_net = NETWORK_ID_RESET;
   logic [31:0]   cfg_key = KEY_WORD_RESET;
   logic [15:0]   prev_nonce = '0;

   // monitor side
   logic          req_fire = 1'b0;
   int            bytes_taken = 0;
   int            csr_beats = 0;
   int            quiet_cycles = 0;
   int            errors = 0;
   rsp_type       verdicts[$];

   // frame checker state
   int            rx_pos;
   logic [15:0]   crc_run;
   logic [31:0]   keystream;
   logic [15:0]   nonce_run;
   logic          head_match;
   logic [15:0]   trailer_run;
   logic [7:0]    plain_bytes[PAYLOAD_LEN];
   logic [15:0]   last_good_nonce;
   logic          fresh_after_reset;
   logic [7:0]    net_id_reg;
   logic [31:0]   key_reg;

   secure_frame_receiver_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // modbus crc, one byte, lsb first
   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      repeat (8) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] xorshift_step(input logic [31:0] s);
      logic [31:0] x;
      x = s ^ (s << 13);
      x = x ^ (x >> 17);
      return x ^ (x << 5);
   endfunction

   task automatic restart_frame();
      rx_pos      = 0;
      crc_run     = CRC_INIT;
      keystream   = '0;
      nonce_run   = '0;
      head_match  = 1'b0;
      trailer_run = '0;
   endtask

   // one accepted byte; a verdict is queued on the last byte of a datagram
   task automatic absorb_byte(input req_type beat);
      rsp_type    verdict;
      status_type code;
      if (rx_pos < MAX_DATAGRAM_BYTES) begin
         if (rx_pos < CRC_SPAN) begin
            crc_run = crc16_step(crc_run, beat.rx_byte);
         end
         if (rx_pos == POS_HEAD) begin
            head_match = (beat.rx_byte == net_id_reg);
         end else if (rx_pos == POS_NONCE_LO) begin
            nonce_run[7:0] = beat.rx_byte;
         end else if (rx_pos == POS_NONCE_HI) begin
            nonce_run[15:8] = beat.rx_byte;
            keystream = key_reg ^ {nonce_run, nonce_run};
            if (keystream == '0) begin
               keystream = SEED_FALLBACK;
            end
         end else if (rx_pos < CRC_SPAN) begin
            keystream = xorshift_step(keystream);
            plain_bytes[rx_pos - POS_PAYLOAD] = beat.rx_byte ^ keystream[7:0];
         end else if (rx_pos == POS_TRAIL_LO) begin
            trailer_run[7:0] = beat.rx_byte;
         end else if (rx_pos == POS_TRAIL_HI) begin
            trailer_run[15:8] = beat.rx_byte;
         end
         rx_pos++;
      end
      if (beat.frame_end) begin
         verdict = '0;
         // length and id first, then crc, then replay
         if (rx_pos != FRAME_LEN || !head_match) begin
            code = STATUS_BAD_LEN;
         end else if (crc_run != trailer_run) begin
            code = STATUS_BAD_CRC;
         end else if (!fresh_after_reset && nonce_run == last_good_nonce) begin
            code = STATUS_REPLAY;
         end else begin
            code = STATUS_OK;
         end
         verdict.status = code;
         if (code == STATUS_OK) begin
            fresh_after_reset   = 1'b0;
            last_good_nonce     = nonce_run;
            verdict.sensor_id   = plain_bytes[0];
            verdict.temperature = {plain_bytes[4], plain_bytes[3], plain_bytes[2],
                                   plain_bytes[1]};
            verdict.humidity    = {plain_bytes[6], plain_bytes[5]};
            verdict.pressure    = {plain_bytes[10], plain_bytes[9], plain_bytes[8],
                                   plain_bytes[7]};
            verdict.light       = {plain_bytes[14], plain_bytes[13], plain_bytes[12],
                                   plain_bytes[11]};
         end
         verdicts.push_back(verdict);
         restart_frame();
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // driver: new beat only once the previous one has gone
   always @(negedge clock) begin : drive
      int gap_pct;
      int stall_pct;
      case (flow)
         FLOW_SEND_GAPS:   begin gap_pct = 85; stall_pct = 0;  end
         FLOW_RECV_STALLS: begin gap_pct = 0;  stall_pct = 85; end
         FLOW_BOTH:        begin gap_pct = 21; stall_pct = 21; end
         default:          begin gap_pct = 0;  stall_pct = 0;  end
      endcase
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_fire) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
               req_data  <= pending_bytes.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // monitor: registers, input bytes, results, watchdog
   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         req_fire <= 1'b0;
         restart_frame();
         foreach (plain_bytes[i]) plain_bytes[i] = '0;
         last_good_nonce   = '0;
         fresh_after_reset = 1'b1;
         net_id_reg        = NETWORK_ID_RESET;
         key_reg           = KEY_WORD_RESET;
         quiet_cycles      = 0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_NETWORK_ID: net_id_reg = csr_data[7:0];
               CSR_KEY_WORD:   key_reg    = csr_data;
               default: begin
               end
            endcase
            csr_beats++;
         end
         // results before bytes, so a result can never meet its own byte
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (verdicts.size() == 0) begin
               $display("%0t: result with none expected, expected none, actual %h",
                        $time, got);
               errors++;
            end else begin
               want = verdicts.pop_front();
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("sensor_id", 32'(want.sensor_id), 32'(got.sensor_id));
               check_field("temperature", want.temperature, got.temperature);
               check_field("humidity", 32'(want.humidity), 32'(got.humidity));
               check_field("pressure", want.pressure, got.pressure);
               check_field("light", want.light, got.light);
            end
         end
         if (req_valid && req_ready) begin
            absorb_byte(req_data);
            bytes_taken++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      int seen;
      seen = csr_beats;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(negedge clock); while (csr_beats == seen);
      csr_valid <= 1'b0;
   endtask

   // build a datagram; payload is encrypted from a chosen plaintext
   task automatic queue_frame(input logic [7:0] head, input logic [15:0] nonce,
                              input int len, input bit crc_bad, input fill_type fill);
      logic [7:0]  body[FRAME_LEN];
      logic [15:0] crc;
      logic [31:0] ks;
      logic [7:0]  plain;
      req_type     beat;
      body[POS_HEAD]     = head;
      body[POS_NONCE_LO] = nonce[7:0];
      body[POS_NONCE_HI] = nonce[15:8];
      ks = cfg_key ^ {nonce, nonce};
      if (ks == '0) begin
         ks = SEED_FALLBACK;
      end
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         ks = xorshift_step(ks);
         case (fill)
            FILL_ZERO: plain = 8'h00;
            FILL_ONES: plain = 8'hFF;
            FILL_SIGN: plain = (i == 4) ? 8'h80 : 8'h00;
            default:   plain = 8'($urandom);
         endcase
         body[POS_PAYLOAD + i] = plain ^ ks[7:0];
      end
      crc = CRC_INIT;
      for (int i = 0; i < CRC_SPAN; i++) begin
         crc = crc16_step(crc, body[i]);
      end
      if (crc_bad) begin
         crc = crc ^ 16'($urandom_range(1, 65535));
      end
      body[POS_TRAIL_LO] = crc[7:0];
      body[POS_TRAIL_HI] = crc[15:8];
      for (int i = 0; i < len; i++) begin
         beat.rx_byte   = (i < FRAME_LEN) ? body[i] : 8'($urandom);
         beat.frame_end = (i == len - 1);
         pending_bytes.push_back(beat);
         bytes_queued++;
      end
   endtask

   // mostly well-formed frames, plus rejects and noise
   task automatic queue_traffic(input int budget);
      int          start;
      int          pick;
      int          count;
      logic [15:0] n;
      fill_type    fill;
      req_type     beat;
      start = bytes_queued;
      while (bytes_queued - start < budget) begin
         pick = $urandom_range(0, 99);
         n    = 16'($urandom);
         fill = ($urandom_range(0, 7) < 5) ? FILL_RANDOM : fill_type'($urandom_range(1, 3));
         if (pick < 48) begin
            queue_frame(cfg_net, n, FRAME_LEN, 1'b0, fill);
            prev_nonce = n;
         end else if (pick < 58) begin
            queue_frame(cfg_net, prev_nonce, FRAME_LEN, 1'b0, FILL_RANDOM);
         end else if (pick < 64) begin
            queue_frame(cfg_net, n, FRAME_LEN, 1'b1, FILL_RANDOM);
         end else if (pick < 69) begin
            queue_frame(8'($urandom), n, FRAME_LEN, 1'($urandom), FILL_RANDOM);
         end else if (pick < 76) begin
            queue_frame(cfg_net, n, $urandom_range(1, FRAME_LEN - 1), 1'b0, FILL_RANDOM);
         end else if (pick < 82) begin
            queue_frame(cfg_net, n, $urandom_range(FRAME_LEN + 1, 40), 1'b0, FILL_RANDOM);
         end else if (pick < 90) begin
            // zero seed where the key allows it
            if (cfg_key[31:16] == cfg_key[15:0]) begin
               n = cfg_key[15:0];
            end
            queue_frame(cfg_net, n, FRAME_LEN, 1'b0, fill);
            prev_nonce = n;
         end else begin
            count = $urandom_range(1, 8);
            for (int i = 0; i < count; i++) begin
               beat.rx_byte   = 8'($urandom);
               beat.frame_end = (i == count - 1) || ($urandom_range(0, 3) == 0);
               pending_bytes.push_back(beat);
               bytes_queued++;
            end
         end
      end
   endtask

   // all bytes taken, all results in, then let the pipeline empty
   task automatic settle();
      do @(negedge clock); while (bytes_taken != bytes_queued || verdicts.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [7:0]  net;
      logic [31:0] key;
      logic [15:0] half;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed frames at default registers
      @(posedge clock);
      flow = FLOW_FREE;
      // first frame: nonce equal to cleared history is still accepted
      queue_frame(cfg_net, 16'h0000, FRAME_LEN, 1'b0, FILL_ZERO);
      queue_frame(cfg_net, 16'h0000, FRAME_LEN, 1'b0, FILL_ONES);
      // crc error wins over replay
      queue_frame(cfg_net, 16'h0000, FRAME_LEN, 1'b1, FILL_RANDOM);
      // wrong id wins over crc error
      queue_frame(cfg_net ^ 8'h01, 16'h0101, FRAME_LEN, 1'b1, FILL_RANDOM);
      queue_frame(cfg_net, 16'h5555, 1, 1'b0, FILL_RANDOM);
      queue_frame(cfg_net, 16'h5555, FRAME_LEN - 1, 1'b0, FILL_RANDOM);
      queue_frame(cfg_net, 16'h5555, FRAME_LEN + 1, 1'b0, FILL_RANDOM);
      // runs past the byte counter saturation
      queue_frame(cfg_net, 16'h5555, 40, 1'b0, FILL_RANDOM);
      queue_frame(cfg_net, 16'hFFFF, FRAME_LEN, 1'b0, FILL_ONES);
      queue_frame(cfg_net, 16'h8000, FRAME_LEN, 1'b0, FILL_SIGN);
      queue_frame(cfg_net, 16'h8000, FRAME_LEN, 1'b0, FILL_RANDOM);
      // rejected frames left the history at the last accepted nonce
      queue_frame(cfg_net, 16'hFFFF, FRAME_LEN, 1'b0, FILL_RANDOM);
      settle();

      // random traffic under several register settings and flow modes
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         half = 16'($urandom);
         case (phase)
            0:       begin net = 8'h00; key = 32'h0000_0000; end
            1:       begin net = 8'hFF; key = 32'hFFFF_FFFF; end
            2:       begin net = 8'($urandom); key = 32'h3C3C_3C3C; end
            default: begin
               net = 8'($urandom);
               key = phase[0] ? {half, half} : $urandom;
            end
         endcase
         write_reg(CSR_NETWORK_ID, {24'h0, net});
         write_reg(CSR_KEY_WORD, key);
         cfg_net = net;
         cfg_key = key;
         @(posedge clock);
         flow = flow_type'(phase % 4);
         queue_traffic(PHASE_BYTES);
         settle();
      end

      if (errors == 0 && verdicts.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[files.f]
src/sfr_pkg.sv
src/sfr_front.sv
src/sfr_queue.sv
src/sfr_back.sv
src/secure_frame_receiver_unit.sv
sim/secure_frame_receiver_unit_test.sv
